FILE: rtl/core/iir_pkg.sv
package iir_pkg;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 24;
  localparam int FRAC_BITS = 20;
  localparam int ACC_W = 48;
  localparam int NUM_W = 44;
  localparam int QUO_W = 44;

  localparam logic [1:0] KIND_STEP = 2'd0;
  localparam logic [1:0] KIND_IN_RESET = 2'd1;
  localparam logic [1:0] KIND_OUT_RESET = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] REG_ORDER = 3'd0;
  localparam logic [2:0] REG_B0 = 3'd1;
  localparam logic [2:0] REG_B1 = 3'd2;
  localparam logic [2:0] REG_B2 = 3'd3;
  localparam logic [2:0] REG_A1 = 3'd4;
  localparam logic [2:0] REG_A2 = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] reg_index;
    logic [COEF_W-1:0] data;
  } cfg_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mac_clear;
    logic mac_en;
    logic mac_is_a;
    logic [1:0] tap;
    logic div_start;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_a_zero;
    logic sum_b_zero;
  } dp_status_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[SAMPLE_W-1:0];
  endfunction
endpackage

FILE: rtl/core/iir_if.sv
interface iir_in_if;
  import iir_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iir_out_if;
  import iir_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iir_cfg_if;
  import iir_pkg::*;
  logic valid;
  logic ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/iir_datapath.sv
module iir_datapath #(
  parameter int MAX_ORDER = 2
) (
  input  logic clk,
  input  logic rst,
  input  iir_pkg::cfg_item_t cfg,
  input  logic cfg_we,
  input  iir_pkg::in_item_t in_item,
  input  iir_pkg::dp_cmd_t cmd,
  output iir_pkg::dp_status_t stat,
  output logic [1:0] order_eff,
  output logic [1:0] kind,
  output iir_pkg::out_item_t result
);
  import iir_pkg::*;

  logic [1:0] filter_order;
  logic signed [COEF_W-1:0] bcoef [0:2];
  logic signed [COEF_W-1:0] acoef [1:2];
  logic signed [SAMPLE_W-1:0] uh [0:MAX_ORDER-1];
  logic signed [SAMPLE_W-1:0] yh [0:MAX_ORDER-1];
  logic signed [SAMPLE_W-1:0] x;
  logic [1:0] kind_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [COEF_W+1:0] sum_b;
  logic signed [COEF_W+1:0] sum_a;
  logic signed [COEF_W-1:0] mc;
  logic signed [SAMPLE_W-1:0] ms;
  logic signed [COEF_W+SAMPLE_W-1:0] prod;
  // restoring divider on magnitudes
  logic [NUM_W-1:0] dnum;
  logic [COEF_W+1:0] dden;
  logic [COEF_W+2:0] drem;
  logic [COEF_W+2:0] dtrial;
  logic dneg;
  logic [QUO_W:0] qsig;
  logic signed [SAMPLE_W-1:0] qsat;
  logic signed [SAMPLE_W+COEF_W+1:0] dprod;
  logic signed [COEF_W+1:0] divisor;
  logic signed [COEF_W+1:0] mult;

  assign order_eff = (filter_order > 2'(MAX_ORDER)) ? 2'(MAX_ORDER) : filter_order;
  assign kind = kind_r;
  assign stat.sum_a_zero = (sum_a >= -26'sd1) && (sum_a <= 26'sd1);
  assign stat.sum_b_zero = (sum_b >= -26'sd1) && (sum_b <= 26'sd1);

  function automatic logic signed [COEF_W-1:0] bk(input logic [1:0] k);
    return (k <= 2'd2) ? bcoef[k] : '0;
  endfunction
  function automatic logic signed [COEF_W-1:0] ak(input logic [1:0] k);
    if (k == 2'd1) return acoef[1];
    if (k == 2'd2) return acoef[2];
    return '0;
  endfunction
  function automatic logic signed [SAMPLE_W-1:0] uk(input logic [1:0] k);
    logic signed [SAMPLE_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_ORDER; i++) if (k == 2'(i + 1)) r = uh[i];
    return r;
  endfunction
  function automatic logic signed [SAMPLE_W-1:0] yk(input logic [1:0] k);
    logic signed [SAMPLE_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_ORDER; i++) if (k == 2'(i + 1)) r = yh[i];
    return r;
  endfunction

  always_comb begin
    mc = cmd.mac_is_a ? ak(cmd.tap) : bk(cmd.tap);
    ms = (cmd.tap == 2'd0) ? x : (cmd.mac_is_a ? yk(cmd.tap) : uk(cmd.tap));
    prod = mc * ms;
    dtrial = {drem[COEF_W+1:0], dnum[NUM_W-1]} - {1'b0, dden};
    qsig = dneg ? -{1'b0, dnum} : {1'b0, dnum};
    qsat = sat16(ACC_W'($signed(qsig)));
    divisor = (kind_r == KIND_IN_RESET) ? sum_a : sum_b;
    mult = (kind_r == KIND_IN_RESET) ? sum_b : sum_a;
    dprod = x * mult;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= '0;
      bcoef[0] <= 24'sd1048576;
      bcoef[1] <= '0;
      bcoef[2] <= '0;
      acoef[1] <= '0;
      acoef[2] <= '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        uh[i] <= '0;
        yh[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg.reg_index)
          REG_ORDER: filter_order <= cfg.data[1:0];
          REG_B0: bcoef[0] <= cfg.data;
          REG_B1: bcoef[1] <= cfg.data;
          REG_B2: bcoef[2] <= cfg.data;
          REG_A1: acoef[1] <= cfg.data;
          REG_A2: acoef[2] <= cfg.data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        case (kind_r)
          KIND_STEP: begin
            for (int i = MAX_ORDER - 1; i > 0; i--) begin
              uh[i] <= uh[i-1];
              yh[i] <= yh[i-1];
            end
            uh[0] <= x;
            yh[0] <= sat16(acc >>> FRAC_BITS);
          end
          KIND_IN_RESET: begin
            for (int i = 0; i < MAX_ORDER; i++) begin
              uh[i] <= stat.sum_a_zero ? '0 : x;
              yh[i] <= stat.sum_a_zero ? '0 : qsat;
            end
          end
          KIND_OUT_RESET: begin
            for (int i = 0; i < MAX_ORDER; i++) begin
              uh[i] <= (stat.sum_a_zero || stat.sum_b_zero) ? '0 : qsat;
              yh[i] <= (stat.sum_a_zero || stat.sum_b_zero) ? '0 : x;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= in_item.sample;
      kind_r <= in_item.kind;
    end
    if (cmd.mac_clear) begin
      acc <= '0;
      sum_b <= '0;
      sum_a <= 26'sd1048576;
    end else if (cmd.mac_en) begin
      if (cmd.mac_is_a) acc <= acc - ACC_W'(prod);
      else acc <= acc + ACC_W'(prod);
      if (cmd.mac_is_a) sum_a <= sum_a + (COEF_W+2)'(mc);
      else sum_b <= sum_b + (COEF_W+2)'(mc);
    end
    if (cmd.div_start) begin
      dneg <= dprod[SAMPLE_W+COEF_W+1] ^ divisor[COEF_W+1];
      dnum <= NUM_W'(dprod[SAMPLE_W+COEF_W+1] ? -dprod : dprod);
      dden <= divisor[COEF_W+1] ? -divisor : divisor;
      drem <= '0;
    end else if (cmd.div_step) begin
      if (!dtrial[COEF_W+2]) begin
        drem <= dtrial;
        dnum <= {dnum[NUM_W-2:0], 1'b1};
      end else begin
        drem <= {drem[COEF_W+1:0], dnum[NUM_W-1]};
        dnum <= {dnum[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      case (kind_r)
        KIND_STEP: begin
          result.status <= 1'b0;
          result.out_sample <= sat16(acc >>> FRAC_BITS);
        end
        KIND_IN_RESET: begin
          result.status <= 1'b0;
          result.out_sample <= stat.sum_a_zero ? '0 : qsat;
        end
        KIND_OUT_RESET: begin
          result.status <= stat.sum_a_zero || stat.sum_b_zero;
          result.out_sample <= (stat.sum_a_zero || stat.sum_b_zero) ? '0 : x;
        end
        default: begin
          result.status <= 1'b0;
          result.out_sample <= '0;
        end
      endcase
    end
  end
endmodule

FILE: rtl/core/iir_ctrl.sv
module iir_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic [1:0] order_eff,
  input  logic [1:0] kind,
  output iir_pkg::dp_cmd_t cmd
);
  import iir_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_B = 3'd1;
  localparam logic [2:0] S_A = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] tap;
  logic [1:0] tap_next;
  logic [5:0] cnt;
  logic [5:0] cnt_next;
  logic out_full;

  assign in_ready = (state == S_IDLE) && (!out_full || out_ready);
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    tap_next = tap;
    cnt_next = cnt;
    cmd = '0;
    cmd.tap = tap;
    case (state)
      S_IDLE: begin
        cmd.mac_clear = 1'b1;
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          tap_next = '0;
          state_next = S_B;
        end
      end
      S_B: begin
        cmd.mac_en = 1'b1;
        if (tap == order_eff) begin
          tap_next = 2'd1;
          state_next = (order_eff == 2'd0) ? S_DSTART : S_A;
        end else tap_next = tap + 2'd1;
      end
      S_A: begin
        cmd.mac_en = 1'b1;
        cmd.mac_is_a = 1'b1;
        if (tap == order_eff) state_next = S_DSTART;
        else tap_next = tap + 2'd1;
      end
      S_DSTART: begin
        if (kind == KIND_STEP || kind == KIND_UNUSED) state_next = S_FIN;
        else begin
          cmd.div_start = 1'b1;
          cnt_next = 6'(NUM_W - 1);
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt - 6'd1;
        if (cnt == 6'd0) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap <= '0;
      cnt <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      tap <= tap_next;
      cnt <= cnt_next;
      if (cmd.finish) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end
endmodule

FILE: rtl/core/iir_direct_form_filter.sv
// Direct form I IIR filter with Q3.20 coefficients and 16-bit samples. One item is
// worked at a time: a filter step runs the b taps and then the a taps through a single
// shared multiply-accumulate and registers the result; steady-state resets also run a
// restoring divider for the DC gain ratio before the result is registered.
// Input is taken only when the previous result has been or is being taken.
// Configuration writes are accepted at any time and must be made while idle.
module iir_direct_form_filter #(
  parameter int MAX_ORDER = 2
) (
  input logic clk,
  input logic rst,
  iir_in_if.sink in_ch,
  iir_out_if.source out_ch,
  iir_cfg_if.sink cfg
);
  import iir_pkg::*;

  dp_cmd_t cmd;
  dp_status_t stat;
  logic [1:0] order_eff;
  logic [1:0] kind;

  assign cfg.ready = 1'b1;

  iir_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .order_eff(order_eff), .kind(kind), .cmd(cmd)
  );

  iir_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk(clk), .rst(rst),
    .cfg(cfg.data), .cfg_we(cfg.valid),
    .in_item(in_ch.data), .cmd(cmd), .stat(stat),
    .order_eff(order_eff), .kind(kind), .result(out_ch.data)
  );
endmodule
